/* rtl/core/spt_pkg.sv */
// Shared types and constants for the shell pipeline tokenizer.
// Used by the front, the queue, the back and the top level; no dependencies.
package spt_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_BYTE   = 3'd0;
    localparam kind_t KIND_TEND   = 3'd1;
    localparam kind_t KIND_SEP    = 3'd2;
    localparam kind_t KIND_ACCEPT = 3'd3;
    localparam kind_t KIND_REJECT = 3'd4;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } qmode_t;

    localparam logic [7:0] CH_PIPE      = 8'h7C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam int MAX_RES = 3;

    // Results caused by one input byte; only the first slot can be a token byte.
    typedef struct packed {
        logic [1:0]          cnt;
        kind_t [MAX_RES-1:0] kinds;
        logic [7:0]          data;
    } entry_t;

endpackage

/* rtl/core/spt_front.sv */
// Front part: accepts input bytes, tracks quote and escape state and builds
// the group of results each byte causes. Depends on spt_pkg.
module spt_front
    import spt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       push_valid,
    output entry_t     push_entry,
    input  logic       push_ready
);

    qmode_t qmode_reg, qmode_next;
    logic   esc_reg, esc_next;
    logic   tok_reg, tok_next;
    logic   seg_reg, seg_next;
    logic   after_reg, after_next;
    logic   err_reg, err_next;
    entry_t ent;

    assign s_tready = push_ready;

    always_comb begin
        logic [1:0] n;
        logic       is_ws;
        logic       rej;
        n          = 2'd0;
        rej        = 1'b0;
        ent        = '0;
        qmode_next = qmode_reg;
        esc_next   = esc_reg;
        tok_next   = tok_reg;
        seg_next   = seg_reg;
        after_next = after_reg;
        err_next   = err_reg;
        is_ws      = (s_tdata == CH_SPACE) || (s_tdata >= CH_TAB && s_tdata <= CH_CR);

        if (!err_reg) begin
            if (esc_reg) begin
                esc_next     = 1'b0;
                ent.kinds[0] = KIND_BYTE;
                ent.data     = s_tdata;
                n            = 2'd1;
            end else if (qmode_reg == QM_NONE && s_tdata == CH_PIPE) begin
                if (tok_reg) begin
                    ent.kinds[0] = KIND_TEND;
                    n            = 2'd1;
                end
                tok_next = 1'b0;
                if (!seg_reg) begin
                    ent.kinds[n] = KIND_REJECT;
                    n            = n + 2'd1;
                    err_next     = 1'b1;
                end else begin
                    ent.kinds[n] = KIND_SEP;
                    n            = n + 2'd1;
                    after_next   = 1'b1;
                    seg_next     = 1'b0;
                end
            end else if (qmode_reg == QM_NONE && is_ws) begin
                if (tok_reg) begin
                    ent.kinds[0] = KIND_TEND;
                    n            = 2'd1;
                end
                tok_next = 1'b0;
            end else begin
                tok_next = 1'b1;
                seg_next = 1'b1;
                if (s_tdata == CH_SQUOTE && qmode_reg != QM_DOUBLE) begin
                    qmode_next = (qmode_reg == QM_SINGLE) ? QM_NONE : QM_SINGLE;
                end else if (s_tdata == CH_DQUOTE && qmode_reg != QM_SINGLE) begin
                    qmode_next = (qmode_reg == QM_DOUBLE) ? QM_NONE : QM_DOUBLE;
                end else if (s_tdata == CH_BACKSLASH && qmode_reg != QM_SINGLE) begin
                    esc_next = 1'b1;
                end else begin
                    ent.kinds[0] = KIND_BYTE;
                    ent.data     = s_tdata;
                    n            = 2'd1;
                end
            end

            if (s_tlast && !err_next) begin
                if (esc_next && qmode_next == QM_DOUBLE) begin
                    rej = 1'b1;
                end
                if (qmode_next != QM_NONE) begin
                    rej = 1'b1;
                end
                if (rej) begin
                    ent.kinds[n] = KIND_REJECT;
                    n            = n + 2'd1;
                end else begin
                    if (tok_next) begin
                        ent.kinds[n] = KIND_TEND;
                        n            = n + 2'd1;
                    end
                    if (after_next && !seg_next) begin
                        ent.kinds[n] = KIND_REJECT;
                    end else begin
                        ent.kinds[n] = KIND_ACCEPT;
                    end
                    n = n + 2'd1;
                end
            end
        end

        if (s_tlast) begin
            qmode_next = QM_NONE;
            esc_next   = 1'b0;
            tok_next   = 1'b0;
            seg_next   = 1'b0;
            after_next = 1'b0;
            err_next   = 1'b0;
        end
        ent.cnt = n;
    end

    assign push_valid = s_tvalid && push_ready && (ent.cnt != 2'd0);
    assign push_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qmode_reg <= QM_NONE;
            esc_reg   <= 1'b0;
            tok_reg   <= 1'b0;
            seg_reg   <= 1'b0;
            after_reg <= 1'b0;
            err_reg   <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            qmode_reg <= qmode_next;
            esc_reg   <= esc_next;
            tok_reg   <= tok_next;
            seg_reg   <= seg_next;
            after_reg <= after_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* rtl/core/spt_queue.sv */
// Short queue of result groups between the front and the back part.
// Depends on spt_pkg for the entry type.
module spt_queue
    import spt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    input  entry_t push_entry,
    output logic   push_ready,
    input  logic   pop,
    output logic   pop_valid,
    output entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/spt_back.sv */
// Back part: takes result groups from the queue and sends them out one
// result per transaction from an output register. Depends on spt_pkg.
module spt_back
    import spt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    input  entry_t      pop_entry,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic       busy_reg;
    entry_t     ent_reg;
    logic [1:0] idx_reg;
    logic       last;
    kind_t      kind;

    assign kind     = ent_reg.kinds[idx_reg];
    assign last     = (idx_reg == ent_reg.cnt - 2'd1);
    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = (kind == KIND_BYTE) ? ent_reg.data : 8'd0;
    assign m_tuser  = kind;
    assign pop      = pop_valid && (!busy_reg || (m_tready && last));

    always_ff @(posedge aclk) begin
        if (pop) begin
            ent_reg <= pop_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (busy_reg && m_tready) begin
            if (last) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

/* rtl/core/shell_pipeline_tokenizer.sv */
// Top level of the shell pipeline tokenizer: front, queue and back part.
// Depends on spt_pkg, spt_front, spt_queue and spt_back.
//
// One command-line byte enters per transaction, with tlast on the last byte
// of a line, and a new byte is taken every cycle while the result queue has
// room. Each byte causes zero to three results, which leave one per cycle
// from the output register while m_tready is high; tlast marks the final
// result of each byte. A line ends with an accept or a reject result; after
// a reject the rest of the line gives nothing and the consumer drops that
// line's earlier results. While m_tready is high, the sustained rate is one
// byte per cycle while bytes give one result at most, else one result per cycle.
module shell_pipeline_tokenizer
    import spt_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [2:0] out_kind
    output logic        m_tlast
);

    logic   push_valid, push_ready, pop, pop_valid;
    entry_t push_entry, pop_entry;

    spt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    spt_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    spt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= KIND_REJECT))
        else $error("Result kind out of range.");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_BYTE) |-> (m_tdata == 8'd0))
        else $error("Nonzero byte on a result that is not a token byte.");

    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (push_entry.cnt != 2'd0 && push_entry.cnt <= 2'd3 && push_ready))
        else $error("Queue push of an empty result group or while full.");

    a_pop_on_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && m_tvalid) |-> (m_tready && m_tlast))
        else $error("Queue popped while a result group is still being sent.");
`endif

endmodule

/* verif/tb_shell_pipeline_tokenizer.sv */
// Self-checking testbench for shell_pipeline_tokenizer: directed lines, then random
// well-formed, broken and noise lines, with a scoreboard class that predicts each result.
// Depends on spt_pkg and the shell_pipeline_tokenizer RTL.
module tb_shell_pipeline_tokenizer;
    import spt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 90;

    class token_scoreboard;
        typedef struct {
            kind_t      kind;
            logic [7:0] data;
            logic       last;
        } result_t;

        result_t    expected_q[$];
        result_t    run_q[$];
        qmode_t     qmode;
        bit         escaped;
        bit         tok_open;
        bit         seg_has_tok;
        bit         after_sep;
        bit         line_err;
        int         errors;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            qmode       = QM_NONE;
            escaped     = 1'b0;
            tok_open    = 1'b0;
            seg_has_tok = 1'b0;
            after_sep   = 1'b0;
            line_err    = 1'b0;
        endfunction

        function void add_result(kind_t k, logic [7:0] d);
            result_t r;
            r.kind = k;
            r.data = (k == KIND_BYTE) ? d : 8'h00;
            r.last = 1'b0;
            run_q.insert(run_q.size(), r);
        endfunction

        function void end_token();
            if (tok_open) begin
                add_result(KIND_TEND, 8'h00);
                tok_open = 1'b0;
            end
        endfunction

        function void flag_reject();
            add_result(KIND_REJECT, 8'h00);
            line_err = 1'b1;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void take_char(logic [7:0] c);
            if (escaped) begin
                escaped = 1'b0;
                add_result(KIND_BYTE, c);
                return;
            end
            if (qmode == QM_NONE && c == CH_PIPE) begin
                end_token();
                if (!seg_has_tok) begin
                    flag_reject();
                    return;
                end
                add_result(KIND_SEP, 8'h00);
                after_sep   = 1'b1;
                seg_has_tok = 1'b0;
                return;
            end
            if (qmode == QM_NONE && is_blank(c)) begin
                end_token();
                return;
            end
            tok_open    = 1'b1;
            seg_has_tok = 1'b1;
            if (c == CH_SQUOTE && qmode != QM_DOUBLE) begin
                qmode = (qmode == QM_SINGLE) ? QM_NONE : QM_SINGLE;
            end else if (c == CH_DQUOTE && qmode != QM_SINGLE) begin
                qmode = (qmode == QM_DOUBLE) ? QM_NONE : QM_DOUBLE;
            end else if (c == CH_BACKSLASH && qmode != QM_SINGLE) begin
                escaped = 1'b1;
            end else begin
                add_result(KIND_BYTE, c);
            end
        endfunction

        function void finish_line();
            if (escaped && qmode == QM_DOUBLE) begin
                flag_reject();
                return;
            end
            escaped = 1'b0;
            if (qmode != QM_NONE) begin
                flag_reject();
                return;
            end
            end_token();
            if (after_sep && !seg_has_tok) begin
                flag_reject();
            end else begin
                add_result(KIND_ACCEPT, 8'h00);
            end
        endfunction

        function void note_byte(logic [7:0] c, logic eol);
            run_q.delete();
            if (!line_err) begin
                take_char(c);
                if (eol && !line_err) begin
                    finish_line();
                end
            end
            if (eol) begin
                clear_line();
            end
            if (run_q.size() > 0) begin
                run_q[run_q.size() - 1].last = 1'b1;
            end
            foreach (run_q[i]) begin
                expected_q.insert(expected_q.size(), run_q[i]);
            end
        endfunction

        function void check_result(logic [2:0] tuser, logic [7:0] tdata, logic tlast);
            result_t    want;
            kind_t      got_kind;
            logic [7:0] got_byte;
            got_kind = tuser;
            got_byte = tdata;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 20) begin
                    $display("%0t: unexpected result: kind %0d byte %02h last %0b",
                             $time, got_kind, got_byte, tlast);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got_kind !== want.kind) begin
                errors++;
                if (errors <= 20) begin
                    $display("%0t: out_kind mismatch: expected %0d, actual %0d",
                             $time, want.kind, got_kind);
                end
            end
            if (got_byte !== want.data) begin
                errors++;
                if (errors <= 20) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, got_byte);
                end
            end
            if (tlast !== want.last) begin
                errors++;
                if (errors <= 20) begin
                    $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                             $time, want.last, tlast);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard sb = new();

    logic [7:0]  line_buf[$];
    int unsigned items_sent     = 0;
    int          idle_cycles    = 0;
    int          rx_hold_cycles = 0;
    bit          rx_fast        = 1'b0;
    bit          tx_burst       = 1'b0;

    shell_pipeline_tokenizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        bit moved;
        moved = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_byte(s_tdata, s_tlast);
            moved = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata, m_tlast);
            moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("** shell_pipeline_tokenizer: FAILED **");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            if ($urandom_range(0, 31) == 0) begin
                rx_fast = !rx_fast;
            end
            gap = rx_fast ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eol);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) begin
            send_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    function automatic void append_char(logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic bit is_special(logic [7:0] c);
        return c == CH_PIPE || c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BACKSLASH ||
               c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0) begin
            c = 8'h61 + 8'($urandom_range(0, 25));
        end else begin
            do c = 8'($urandom_range(0, 255)); while (is_special(c));
        end
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 4))
            0: return CH_PIPE;
            1: return CH_SQUOTE;
            2: return CH_DQUOTE;
            3: return CH_BACKSLASH;
            default: return blank_char();
        endcase
    endfunction

    function automatic void add_word();
        logic [7:0] c;
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) append_char(plain_char());
                end
                2: begin
                    append_char(CH_SQUOTE);
                    repeat ($urandom_range(0, 3)) begin
                        do c = 8'($urandom_range(0, 255)); while (c == CH_SQUOTE);
                        append_char(c);
                    end
                    append_char(CH_SQUOTE);
                end
                3: begin
                    append_char(CH_DQUOTE);
                    repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            append_char(CH_BACKSLASH);
                            append_char(8'($urandom_range(0, 255)));
                        end else begin
                            do c = 8'($urandom_range(0, 255));
                            while (c == CH_DQUOTE || c == CH_BACKSLASH);
                            append_char(c);
                        end
                    end
                    append_char(CH_DQUOTE);
                end
                default: begin
                    append_char(CH_BACKSLASH);
                    append_char(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endfunction

    function automatic void make_line();
        int cmds;
        int words;
        line_buf.delete();
        if ($urandom_range(0, 3) == 0) append_char(blank_char());
        cmds = $urandom_range(1, 3);
        for (int i = 0; i < cmds; i++) begin
            if (i > 0) begin
                if ($urandom_range(0, 1) == 0) append_char(blank_char());
                append_char(CH_PIPE);
                if ($urandom_range(0, 1) == 0) append_char(blank_char());
            end
            words = $urandom_range(1, 3);
            for (int j = 0; j < words; j++) begin
                if (j > 0) append_char(blank_char());
                add_word();
            end
        end
        if ($urandom_range(0, 3) == 0) append_char(blank_char());
    endfunction

    function automatic void break_line();
        case ($urandom_range(0, 2))
            0: line_buf.insert($urandom_range(0, line_buf.size()), special_char());
            1: line_buf = line_buf[0:$urandom_range(0, line_buf.size() - 1)];
            default: append_char(($urandom_range(0, 1) == 0) ? CH_PIPE : CH_BACKSLASH);
        endcase
    endfunction

    function automatic void make_noise_line();
        line_buf.delete();
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 1) == 0) begin
                append_char(special_char());
            end else begin
                append_char(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned directed_items;
        int          line_no;
        int unsigned burst_start;
        int          pick;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        line_buf = '{8'h00, 8'hFF, CH_PIPE, 8'h78};
        send_line();
        line_buf = '{CH_SPACE, CH_TAB, CH_CR};
        send_line();
        line_buf = '{CH_DQUOTE, CH_DQUOTE, CH_BACKSLASH, CH_PIPE};
        send_line();
        line_buf = '{CH_PIPE, 8'h61};
        send_line();
        line_buf = '{CH_DQUOTE, 8'h61, CH_BACKSLASH};
        send_line();
        line_buf = '{8'h62, CH_BACKSLASH};
        send_line();
        line_buf = '{CH_SQUOTE, 8'h78};
        send_line();
        line_buf = '{8'h63, CH_PIPE};
        send_line();
        line_buf = '{CH_SQUOTE, CH_BACKSLASH, CH_SQUOTE};
        send_line();
        directed_items = items_sent;

        line_no = 0;
        while (items_sent - directed_items < RANDOM_ITEMS) begin
            line_no++;
            if (line_no == 12) begin
                // Stall the result side while bytes keep coming, so the queue fills.
                rx_hold_cycles = HOLD_CYCLES;
                tx_burst = 1'b1;
                burst_start = items_sent;
                while (items_sent - burst_start < 30) begin
                    make_line();
                    send_line();
                end
            end
            if (line_no == 25 || line_no == 50) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            tx_burst = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                make_line();
            end else if (pick < 17) begin
                make_line();
                break_line();
            end else begin
                make_noise_line();
            end
            send_line();
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** shell_pipeline_tokenizer: PASSED **");
        end else begin
            $display("** shell_pipeline_tokenizer: FAILED **");
        end
        $finish;
    end
endmodule
